// File: rtl/core/matrix3x3_inverse_unit_defines.svh
// assertion macros for the 3x3 matrix inverse unit
`ifndef MATRIX3X3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3X3_INVERSE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/m3i_pkg.sv
// shared types, widths and helpers of the 3x3 matrix inverse unit
package m3i_pkg;

  localparam int IN_W         = 32;
  localparam int OUT_W        = 32;
  localparam int NENT         = 9;
  localparam int PROD_W       = 64;
  localparam int COF_W        = 65;
  localparam int CMAG_W       = 64;
  localparam int PART_W       = 66;
  localparam int DET_W        = 98;
  localparam int DMAG_W       = 97;
  localparam int NTERM        = 3;
  localparam int QUO_W        = 33;
  localparam int QSTEPS       = QUO_W + 1;
  localparam int FRONT_STAGES = 6;

  // cofactor i = e[CP_A]*e[CP_B] - e[CN_A]*e[CN_B], row-major entries
  localparam int CP_A [NENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CP_B [NENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CN_A [NENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int CN_B [NENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  // first-column expansion entries
  localparam int EXP_E [NTERM] = '{0, 3, 6};

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [IN_W-1:0] entry_t;

  typedef struct packed {
    logic [DMAG_W-1:0] mag;
    logic              neg;
    logic              zero;
  } det_info_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } lane_res_t;

  function automatic logic [OUT_W-1:0] sat32(input logic neg, input logic big,
                                             input logic [QUO_W-1:0] mag);
    logic [QUO_W-1:0] nmag;
    nmag = -mag;
    if (!neg) begin
      if (big || (mag > QUO_W'(SAT_POS))) return SAT_POS;
      return mag[OUT_W-1:0];
    end
    if (big || (mag > QUO_W'(SAT_NEG))) return SAT_NEG;
    return nmag[OUT_W-1:0];
  endfunction

endpackage

// File: rtl/core/m3i_front.sv
// cofactor, determinant and magnitude stages ahead of the divider lanes
module m3i_front import m3i_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic [FRONT_STAGES-1:0]             ld_i,
  input  entry_t                              e_i [NENT],
  output logic [CMAG_W+2*FRAC_BITS-1:0]       nmag_o [NENT],
  output logic                                nneg_o [NENT],
  output det_info_t                           det_o
);

  localparam int NW = CMAG_W + 2 * FRAC_BITS;

  logic signed [PROD_W-1:0] pa_q [NENT];
  logic signed [PROD_W-1:0] pb_q [NENT];
  entry_t                   ex0_q [NTERM];
  entry_t                   ex1_q [NTERM];
  logic signed [COF_W-1:0]  cof1_q [NENT];
  logic signed [COF_W-1:0]  cof2_q [NENT];
  logic signed [COF_W-1:0]  cof3_q [NENT];
  logic signed [COF_W-1:0]  cof4_q [NENT];
  logic signed [PART_W-1:0] plo_q [NTERM];
  logic signed [PART_W-1:0] phi_q [NTERM];
  logic signed [DET_W-1:0]  term_q [NTERM];
  logic signed [DET_W-1:0]  det_q;
  logic signed [DET_W-1:0]  dabs;
  logic signed [COF_W-1:0]  cabs [NENT];
  logic [NW-1:0]            nmag_q [NENT];
  logic                     nneg_q [NENT];
  det_info_t                det_q5;

  always_comb begin
    dabs = det_q[DET_W-1] ? -det_q : det_q;
    for (int i = 0; i < NENT; i++) begin
      cabs[i] = cof4_q[i][COF_W-1] ? -cof4_q[i] : cof4_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NENT; i++) begin
      if (ld_i[0]) begin
        pa_q[i] <= e_i[CP_A[i]] * e_i[CP_B[i]];
        pb_q[i] <= e_i[CN_A[i]] * e_i[CN_B[i]];
      end
      if (ld_i[1]) cof1_q[i] <= COF_W'(pa_q[i]) - COF_W'(pb_q[i]);
      if (ld_i[2]) cof2_q[i] <= cof1_q[i];
      if (ld_i[3]) cof3_q[i] <= cof2_q[i];
      if (ld_i[4]) cof4_q[i] <= cof3_q[i];
      if (ld_i[5]) begin
        nmag_q[i] <= {cabs[i][CMAG_W-1:0], {(2*FRAC_BITS){1'b0}}};
        nneg_q[i] <= cof4_q[i][COF_W-1];
      end
    end
    for (int j = 0; j < NTERM; j++) begin
      if (ld_i[0]) ex0_q[j] <= e_i[EXP_E[j]];
      if (ld_i[1]) ex1_q[j] <= ex0_q[j];
      if (ld_i[2]) begin
        plo_q[j] <= ex1_q[j] * $signed({1'b0, cof1_q[j][IN_W-1:0]});
        phi_q[j] <= ex1_q[j] * $signed(cof1_q[j][COF_W-1:IN_W]);
      end
      if (ld_i[3]) term_q[j] <= (DET_W'(phi_q[j]) <<< IN_W) + DET_W'(plo_q[j]);
    end
    if (ld_i[4]) det_q <= term_q[0] + term_q[1] + term_q[2];
    if (ld_i[5]) begin
      det_q5.mag  <= dabs[DMAG_W-1:0];
      det_q5.neg  <= det_q[DET_W-1];
      det_q5.zero <= (det_q == '0);
    end
  end

  assign nmag_o = nmag_q;
  assign nneg_o = nneg_q;
  assign det_o  = det_q5;

endmodule

// File: rtl/core/m3i_div_lane.sv
// pipelined restoring divider lane: an overflow-check stage, then one quotient bit per stage
module m3i_div_lane import m3i_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic [QSTEPS-1:0]             ld_i,
  input  logic [CMAG_W+2*FRAC_BITS-1:0] nmag_i,
  input  logic                          neg_i,
  input  logic [DMAG_W-1:0]             dstage_i [QSTEPS],
  output lane_res_t                     res_o
);

  localparam int NW = CMAG_W + 2 * FRAC_BITS;
  localparam int CW = ((NW > DMAG_W + QSTEPS) ? NW : DMAG_W + QSTEPS) + 1;

  logic [NW-1:0]    r_q   [QSTEPS];
  logic [QUO_W-1:0] quo_q [QSTEPS];
  logic             ovf_q [QSTEPS];
  logic             neg_q [QSTEPS];

  for (genvar j = 0; j < QSTEPS; j++) begin : g_stage
    localparam int K = QSTEPS - 1 - j;
    logic [NW-1:0] r_in;
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign r_in = nmag_i;
    end else begin : g_next
      assign r_in = r_q[j-1];
    end

    assign dsh  = CW'(dstage_i[j]) << K;
    assign ge   = (CW'(r_in) >= dsh);
    assign diff = CW'(r_in) - dsh;

    if (j == 0) begin : g_ovf
      always_ff @(posedge clk_i) begin
        if (ld_i[j]) begin
          r_q[j]   <= r_in;
          quo_q[j] <= '0;
          ovf_q[j] <= ge;
          neg_q[j] <= neg_i;
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk_i) begin
        if (ld_i[j]) begin
          r_q[j]   <= ge ? diff[NW-1:0] : r_in;
          quo_q[j] <= quo_q[j-1] | (QUO_W'(ge) << K);
          ovf_q[j] <= ovf_q[j-1];
          neg_q[j] <= neg_q[j-1];
        end
      end
    end
  end

  assign res_o.neg = neg_q[QSTEPS-1];
  assign res_o.ovf = ovf_q[QSTEPS-1];
  assign res_o.quo = quo_q[QSTEPS-1];

endmodule

// File: rtl/core/matrix3x3_inverse_unit.sv
// 3x3 matrix inverse by adjugate: front stages, nine divider lanes, merge register
// throughput: one matrix per cycle while the output is not stalled, set by the fully pipelined divider lanes
// each pipeline stage collapses bubbles, so a request is taken while a result waits if any stage is empty
// reset clears only the stage valid flags; payload registers are not reset
module matrix3x3_inverse_unit import m3i_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [287:0]   s_axis_tdata,   // m11 m12 m13 m21 m22 m23 m31 m32 m33
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [319:0]   m_axis_tdata,   // inv11 .. inv33, determinant
  output logic [0:0]     m_axis_tuser    // singular
);

  `include "matrix3x3_inverse_unit_defines.svh"

  localparam int NW  = CMAG_W + 2 * FRAC_BITS;
  localparam int NS  = FRONT_STAGES + QSTEPS + 1;
  localparam int OST = NS - 1;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  entry_t          ent [NENT];
  logic [NW-1:0]   nmag [NENT];
  logic            nneg [NENT];
  det_info_t       det_f;
  det_info_t       dp_q [QSTEPS];
  logic [OUT_W-1:0] dres_q [QSTEPS];
  logic [DMAG_W-1:0] dstage [QSTEPS];
  lane_res_t       lres [NENT];
  logic [DMAG_W-1:0] dshift;
  logic [OUT_W-1:0] dres0;
  logic [OUT_W-1:0] inv_q [NENT];
  logic [OUT_W-1:0] detout_q;
  logic            sing_q;

  // ready ripples back through empty stages
  always_comb begin
    rdy[NS] = m_axis_tready;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
    v_d[0] = rdy[0] ? s_axis_tvalid : v_q[0];
    for (int s = 1; s < NS; s++) begin
      v_d[s] = rdy[s] ? v_q[s-1] : v_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  for (genvar i = 0; i < NENT; i++) begin : g_ent
    assign ent[i] = s_axis_tdata[IN_W*i +: IN_W];
  end

  m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i  (clk_i),
    .ld_i   (rdy[FRONT_STAGES-1:0]),
    .e_i    (ent),
    .nmag_o (nmag),
    .nneg_o (nneg),
    .det_o  (det_f)
  );

  // shared divisor pipeline
  assign dshift = det_f.mag >> (2 * FRAC_BITS);
  assign dres0  = sat32(det_f.neg, |dshift[DMAG_W-1:QUO_W], dshift[QUO_W-1:0]);

  for (genvar j = 0; j < QSTEPS; j++) begin : g_dpipe
    if (j == 0) begin : g_first
      assign dstage[j] = det_f.mag;
      always_ff @(posedge clk_i) begin
        if (rdy[FRONT_STAGES+j]) begin
          dp_q[j]   <= det_f;
          dres_q[j] <= dres0;
        end
      end
    end else begin : g_next
      assign dstage[j] = dp_q[j-1].mag;
      always_ff @(posedge clk_i) begin
        if (rdy[FRONT_STAGES+j]) begin
          dp_q[j]   <= dp_q[j-1];
          dres_q[j] <= dres_q[j-1];
        end
      end
    end
  end

  for (genvar i = 0; i < NENT; i++) begin : g_lane
    m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i    (clk_i),
      .ld_i     (rdy[FRONT_STAGES +: QSTEPS]),
      .nmag_i   (nmag[i]),
      .neg_i    (nneg[i] ^ det_f.neg),
      .dstage_i (dstage),
      .res_o    (lres[i])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk_i) begin
    if (rdy[OST]) begin
      for (int i = 0; i < NENT; i++) begin
        inv_q[i] <= dp_q[QSTEPS-1].zero ? '0 :
                    sat32(lres[i].neg, lres[i].ovf, lres[i].quo);
      end
      detout_q <= dp_q[QSTEPS-1].zero ? '0 : dres_q[QSTEPS-1];
      sing_q   <= dp_q[QSTEPS-1].zero;
    end
  end

  always_comb begin
    for (int i = 0; i < NENT; i++) begin
      m_axis_tdata[OUT_W*i +: OUT_W] = inv_q[i];
    end
    m_axis_tdata[OUT_W*NENT +: OUT_W] = detout_q;
  end

  assign m_axis_tuser  = sing_q;
  assign m_axis_tvalid = v_q[OST];
  assign s_axis_tready = rdy[0];

  `M3I_ASSERT_NOW(a_singular_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "singular result carries nonzero data")
  `M3I_ASSERT_NOW(a_ready_when_empty, !v_q[OST], s_axis_tready, "pipeline stalled with empty output register")
  `M3I_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v_q[0], "accepted request lost at first stage")

endmodule

// File: dv/tb_matrix3x3_inverse_unit.sv
// self-checking testbench of the 3x3 matrix inverse unit with random stalls on both sides
`timescale 1ns / 100ps

module tb_matrix3x3_inverse_unit;
  import m3i_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RAND = 1250;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef logic signed [199:0] wide_t;
  typedef logic [287:0] mat_t;

  typedef struct packed {
    logic [319:0] data;
    logic         singular;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [319:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  mat_t matrix_q[$];
  inverse_t inverse_q[$];
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit req_taken = 1'b0;

  matrix3x3_inverse_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] clamp32(input wide_t v);
    if (v > wide_t'(64'sh7FFF_FFFF)) return SAT_POS;
    if (v < -wide_t'(64'sh8000_0000)) return SAT_NEG;
    return v[31:0];
  endfunction

  function automatic inverse_t invert(input mat_t m);
    wide_t e[9];
    wide_t cf[9];
    wide_t det;
    inverse_t r;
    for (int i = 0; i < 9; i++) e[i] = wide_t'($signed(m[32*i +: 32]));
    cf[0] = e[8] * e[4] - e[7] * e[5];
    cf[1] = e[7] * e[2] - e[8] * e[1];
    cf[2] = e[5] * e[1] - e[4] * e[2];
    cf[3] = e[6] * e[5] - e[8] * e[3];
    cf[4] = e[8] * e[0] - e[6] * e[2];
    cf[5] = e[3] * e[2] - e[5] * e[0];
    cf[6] = e[7] * e[3] - e[6] * e[4];
    cf[7] = e[6] * e[1] - e[7] * e[0];
    cf[8] = e[4] * e[0] - e[3] * e[1];
    det = e[0] * cf[0] + e[3] * cf[1] + e[6] * cf[2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++) r.data[32*i +: 32] = clamp32((cf[i] <<< (2 * FRAC)) / det);
    r.data[288 +: 32] = clamp32(det / (wide_t'(1) <<< (2 * FRAC)));
    return r;
  endfunction

  function automatic logic [31:0] small_entry();
    return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // stimulus
  initial begin
    mat_t m;
    int kind;
    // identity, zero, extremes, singular and near-singular cases
    m = '0;
    m[0 +: 32] = ONE; m[128 +: 32] = ONE; m[256 +: 32] = ONE;
    matrix_q.push_back(m);
    matrix_q.push_back('0);
    matrix_q.push_back({9{32'h7FFF_FFFF}});
    matrix_q.push_back({9{32'h8000_0000}});
    m = '0;
    m[0 +: 32] = 32'h7FFF_FFFF; m[128 +: 32] = 32'h8000_0000; m[256 +: 32] = 32'h7FFF_FFFF;
    matrix_q.push_back(m);
    m = '0;
    m[0 +: 32] = 32'h8000_0000; m[128 +: 32] = 32'h8000_0000; m[256 +: 32] = 32'h8000_0000;
    matrix_q.push_back(m);
    m = '0;
    m[0 +: 32] = 32'd1; m[128 +: 32] = 32'd1; m[256 +: 32] = 32'd1;
    matrix_q.push_back(m);
    m = '0;
    m[0 +: 32] = 32'hFFFF_FFFF; m[128 +: 32] = ONE; m[256 +: 32] = ONE;
    matrix_q.push_back(m);
    m = '0;
    m[64 +: 32] = ONE; m[128 +: 32] = ONE; m[192 +: 32] = ONE;
    matrix_q.push_back(m);
    for (int i = 0; i < 9; i++) m[32*i +: 32] = 32'(i + 1) << 16;
    matrix_q.push_back(m);
    m[256 +: 32] = 32'd10 << 16;
    matrix_q.push_back(m);
    for (int i = 0; i < 9; i++) m[32*i +: 32] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
    matrix_q.push_back(m);
    for (int i = 0; i < 9; i++) m[32*i +: 32] = {$urandom()};
    matrix_q.push_back(m);
    m[192 +: 96] = m[0 +: 96];
    matrix_q.push_back(m);
    for (int i = 0; i < 9; i++) m[32*i +: 32] = (i % 4 == 0) ? 32'h7FFF_FFFF : 32'd1;
    matrix_q.push_back(m);
    for (int n = 0; n < N_RAND; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) m[32*i +: 32] = (kind < 5) ? small_entry() : {$urandom()};
      if (kind == 7) m[192 +: 96] = m[0 +: 96];
      if (kind == 8) begin
        for (int i = 0; i < 9; i++) m[32*i +: 32] = 32'($signed($urandom_range(0, 6)) - 3);
      end
      if (kind == 9) begin
        for (int i = 0; i < 9; i++) m[32*i +: 32] = 32'($signed($urandom_range(0, 6)) - 3) << 16;
      end
      matrix_q.push_back(m);
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (matrix_q.size() == 0 && !s_axis_tvalid);
    wait (inverse_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("matrix3x3_inverse_unit: match");
    end else begin
      $display("matrix3x3_inverse_unit: mismatch");
    end
    $finish;
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (matrix_q.size() > 0) begin
        s_axis_tdata <= matrix_q.pop_front();
        s_axis_tvalid <= 1'b1;
        in_gap <= (cycles % 4000 < 1000) ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_gap <= (cycles % 5000 < 1500) ? 0 : pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    inverse_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix3x3_inverse_unit: mismatch");
      $finish;
    end
    req_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) inverse_q.push_back(invert(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = inverse_q.pop_front();
        for (int i = 0; i < 10; i++) begin
          if (m_axis_tdata[32*i +: 32] !== exp_r.data[32*i +: 32]) begin
            $error("%s: expected %h actual %h", (i == 9) ? "determinant" :
                   $sformatf("inv%0d%0d", i / 3 + 1, i % 3 + 1),
                   exp_r.data[32*i +: 32], m_axis_tdata[32*i +: 32]);
            errors++;
          end
        end
        if (m_axis_tuser[0] !== exp_r.singular) begin
          $error("singular: expected %b actual %b", exp_r.singular, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

endmodule
